// ----- hw/rtl/msca_pkg.sv -----
// ----------------------------------------------------------------------------
// msca_pkg
// Shared types and constants of the MESI snooping cache array.
// ----------------------------------------------------------------------------
`default_nettype none

package msca_pkg;

    localparam int PROCESSORS    = 4;
    localparam int MAX_SETS      = 64;
    localparam int WAYS          = 4;
    localparam int ADDR_BITS     = 48;
    localparam int STAMP_BITS    = 40;
    localparam int SET_BITS      = $clog2(MAX_SETS);
    localparam int PROC_BITS     = 2;
    localparam int WAY_BITS      = 2;
    localparam int LINES_PER_ROW = PROCESSORS * WAYS;

    localparam logic [STAMP_BITS-1:0] STAMP_MAX = 40'hFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        ST_I = 2'd0,
        ST_S = 2'd1,
        ST_E = 2'd2,
        ST_M = 2'd3
    } coh_t;

    typedef enum logic [2:0] {
        OC_HIT         = 3'd0,
        OC_UPGRADE     = 3'd1,
        OC_TRUE_SHARE  = 3'd2,
        OC_FALSE_SHARE = 3'd3,
        OC_COLD        = 3'd4,
        OC_CONFLICT    = 3'd5
    } outcome_t;

    typedef enum logic [1:0] {
        REG_SET_INDEX    = 2'd0,
        REG_BLOCK_OFFSET = 2'd1,
        REG_WAYS         = 2'd2,
        REG_PROCS        = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_EVAL,
        BK_WRITE
    } bk_state_t;

    typedef struct packed {
        logic                 action;
        logic [1:0]           requester;
        logic [ADDR_BITS-1:0] access_address;
    } in_item_t;

    typedef struct packed {
        logic [2:0] outcome;
        logic       bus_used;
        logic       copies_found;
        logic       dirty_eviction;
        logic [1:0] way_used;
        logic [1:0] new_line_state;
    } out_item_t;

    typedef struct packed {
        logic [2:0] set_index_bits;
        logic [3:0] block_offset_bits;
        logic [2:0] ways_in_use;
        logic [2:0] processors_in_use;
    } cfg_t;

    // Classified access handed from the front to the back.
    typedef struct packed {
        logic                 active;
        logic                 write;
        logic [PROC_BITS-1:0] proc;
        logic [ADDR_BITS-1:0] addr;
        logic [ADDR_BITS-1:0] cmp_mask;
        logic [SET_BITS-1:0]  set;
        logic [2:0]           nways;
        logic [2:0]           nprocs;
    } work_t;

    typedef struct packed {
        logic                  valid;
        coh_t                  coh;
        logic                  dirty;
        logic [ADDR_BITS-1:0]  addr;
        logic [STAMP_BITS-1:0] stamp;
    } line_t;

    typedef line_t [LINES_PER_ROW-1:0] row_t;

    typedef struct packed {
        logic clearing;
    } bk_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/msca_front.sv -----
// ----------------------------------------------------------------------------
// msca_front
// Accepts accesses, decodes set and block compare mask, checks the processor.
// ----------------------------------------------------------------------------
`default_nettype none

module msca_front
    import msca_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire cfg_t     cfg,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_data,
    output logic          w_valid,
    input  wire logic     w_ready,
    output work_t         w_data
);

    logic  valid_reg, valid_next;
    work_t item_reg, item_next;

    logic [2:0]           nprocs, nways;
    logic [ADDR_BITS-1:0] block;
    logic [7:0]           set_mask;

    assign s_ready = !valid_reg || w_ready;
    assign w_valid = valid_reg;
    assign w_data  = item_reg;

    always_comb begin
        nprocs = cfg.processors_in_use;
        if (nprocs == 3'd0) begin
            nprocs = 3'd1;
        end else if (nprocs > 3'(PROCESSORS)) begin
            nprocs = 3'(PROCESSORS);
        end
        nways = cfg.ways_in_use;
        if (nways == 3'd0) begin
            nways = 3'd1;
        end else if (nways > 3'(WAYS)) begin
            nways = 3'(WAYS);
        end
        block    = s_data.access_address >> cfg.block_offset_bits;
        set_mask = (8'd1 << cfg.set_index_bits) - 8'd1;

        item_next.active   = ({1'b0, s_data.requester} < nprocs);
        item_next.write    = s_data.action;
        item_next.proc     = s_data.requester;
        item_next.addr     = s_data.access_address;
        item_next.cmp_mask = ~((48'd1 << cfg.block_offset_bits) - 48'd1);
        item_next.set      = block[SET_BITS-1:0] & set_mask[SET_BITS-1:0];
        item_next.nways    = nways;
        item_next.nprocs   = nprocs;

        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (w_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/msca_queue.sv -----
// ----------------------------------------------------------------------------
// msca_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module msca_queue
    import msca_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire work_t in_data,
    output logic       out_valid,
    input  wire logic  out_ready,
    output work_t      out_data
);

    work_t      slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/msca_back.sv -----
// ----------------------------------------------------------------------------
// msca_back
// Reads one set row of all caches, resolves hit, snoop and fill, writes back.
// ----------------------------------------------------------------------------
`default_nettype none

module msca_back
    import msca_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  w_valid,
    output logic       w_ready,
    input  wire work_t w_data,
    output logic       m_valid,
    input  wire logic  m_ready,
    output out_item_t  m_data,
    output bk_status_t status
);

    // One row holds every processor's ways of one set.
    row_t mem [MAX_SETS];

    bk_state_t state_reg, state_next;
    logic [SET_BITS-1:0] clr_cnt_reg, clr_cnt_next;
    work_t     cur_reg, cur_next;
    row_t      rd_row_reg;
    row_t      new_row_reg, new_row;
    out_item_t res_reg, res_next, res_eval;
    logic      m_valid_reg, m_valid_next;
    out_item_t m_data_reg, m_data_next;
    logic [STAMP_BITS-1:0] bus_cnt_reg [PROCESSORS];

    logic                mem_we;
    logic [SET_BITS-1:0] mem_waddr;
    row_t                mem_wdata;
    logic                rd_en;
    logic                cnt_inc;

    // Evaluation temporaries.
    logic [LINES_PER_ROW-1:0] match;
    logic                  found, freed, silent, copies;
    logic [WAY_BITS-1:0]   hit_way, free_way, vic_way, way;
    logic [STAMP_BITS-1:0] lo, stamp;
    coh_t                  st;
    int                    k, own;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign status.clearing = (state_reg == BK_CLEAR);

    always_comb begin
        new_row  = rd_row_reg;
        res_eval = '0;
        found    = 1'b0;
        freed    = 1'b0;
        copies   = 1'b0;
        hit_way  = '0;
        free_way = '0;
        vic_way  = '0;
        way      = '0;
        lo       = STAMP_MAX;
        own      = int'(cur_reg.proc) * WAYS;
        stamp    = bus_cnt_reg[cur_reg.proc];

        for (int q = 0; q < PROCESSORS; q++) begin
            for (int w = 0; w < WAYS; w++) begin
                k = q * WAYS + w;
                match[k] = rd_row_reg[k].valid && (w < int'(cur_reg.nways)) &&
                    (((rd_row_reg[k].addr ^ cur_reg.addr) & cur_reg.cmp_mask) == '0);
            end
        end

        for (int w = WAYS - 1; w >= 0; w--) begin
            if (match[own + w]) begin
                found   = 1'b1;
                hit_way = WAY_BITS'(w);
            end
        end
        st     = rd_row_reg[own + int'(hit_way)].coh;
        silent = found && (st != ST_I) && !(st == ST_S && cur_reg.write);

        if (silent) begin
            if (cur_reg.write && st == ST_E) begin
                new_row[own + int'(hit_way)].coh   = ST_M;
                new_row[own + int'(hit_way)].dirty = 1'b1;
            end
            res_eval.outcome        = OC_HIT;
            res_eval.way_used       = hit_way;
            res_eval.new_line_state = new_row[own + int'(hit_way)].coh;
        end else begin
            res_eval.bus_used = 1'b1;
            // Snoop the other active caches.
            for (int q = 0; q < PROCESSORS; q++) begin
                for (int w = 0; w < WAYS; w++) begin
                    k = q * WAYS + w;
                    if (q < int'(cur_reg.nprocs) && q != int'(cur_reg.proc) && match[k] &&
                        rd_row_reg[k].coh != ST_I) begin
                        new_row[k].coh   = cur_reg.write ? ST_I : ST_S;
                        new_row[k].dirty = 1'b0;
                        copies           = 1'b1;
                    end
                end
            end
            res_eval.copies_found = copies;

            for (int w = WAYS - 1; w >= 0; w--) begin
                if (w < int'(cur_reg.nways) && !rd_row_reg[own + w].valid) begin
                    freed    = 1'b1;
                    free_way = WAY_BITS'(w);
                end
            end
            for (int w = 0; w < WAYS; w++) begin
                if (w < int'(cur_reg.nways) && rd_row_reg[own + w].stamp < lo) begin
                    lo      = rd_row_reg[own + w].stamp;
                    vic_way = WAY_BITS'(w);
                end
            end

            priority if (found) begin
                way = hit_way;
                if (st == ST_I) begin
                    res_eval.outcome = (rd_row_reg[own + int'(way)].addr == cur_reg.addr) ?
                        OC_TRUE_SHARE : OC_FALSE_SHARE;
                    new_row[own + int'(way)].coh   = cur_reg.write ? ST_M : ST_S;
                    new_row[own + int'(way)].dirty = cur_reg.write;
                end else begin
                    res_eval.outcome = OC_UPGRADE;
                    new_row[own + int'(way)].coh   = ST_M;
                    new_row[own + int'(way)].dirty = 1'b1;
                end
            end else if (freed) begin
                way = free_way;
                res_eval.outcome = OC_COLD;
            end else begin
                way = vic_way;
                res_eval.outcome        = OC_CONFLICT;
                res_eval.dirty_eviction = rd_row_reg[own + int'(way)].dirty;
            end

            if (!found) begin
                new_row[own + int'(way)].valid = 1'b1;
                if (cur_reg.write) begin
                    new_row[own + int'(way)].coh   = ST_M;
                    new_row[own + int'(way)].dirty = 1'b1;
                end else begin
                    new_row[own + int'(way)].coh   = copies ? ST_S : ST_E;
                    new_row[own + int'(way)].dirty = 1'b0;
                end
            end
            new_row[own + int'(way)].addr  = cur_reg.addr;
            new_row[own + int'(way)].stamp = stamp;
            res_eval.way_used       = way;
            res_eval.new_line_state = new_row[own + int'(way)].coh;
        end
    end

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        cur_next     = cur_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        w_ready      = 1'b0;
        rd_en        = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = cur_reg.set;
        mem_wdata    = new_row_reg;
        cnt_inc      = 1'b0;
        unique case (state_reg)
            BK_CLEAR: begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == SET_BITS'(MAX_SETS - 1)) begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE: begin
                w_ready = 1'b1;
                if (w_valid) begin
                    cur_next = w_data;
                    if (w_data.active) begin
                        rd_en      = 1'b1;
                        state_next = BK_EVAL;
                    end else begin
                        res_next   = '0;
                        state_next = BK_WRITE;
                    end
                end
            end
            BK_EVAL: begin
                res_next   = res_eval;
                state_next = BK_WRITE;
            end
            BK_WRITE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    mem_we       = cur_reg.active;
                    cnt_inc      = cur_reg.active && res_reg.bus_used;
                    state_next   = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
            for (int p = 0; p < PROCESSORS; p++) begin
                bus_cnt_reg[p] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
            if (cnt_inc) begin
                bus_cnt_reg[cur_reg.proc] <= bus_cnt_reg[cur_reg.proc] + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg     <= cur_next;
        res_reg     <= res_next;
        m_data_reg  <= m_data_next;
        new_row_reg <= new_row;
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_row_reg <= mem[w_data.set];
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/mesi_snooping_cache_array.sv -----
// Path: an access is registered in the front and passes the two-entry queue; for an
// active processor the back then reads the set row, evaluates it and writes it back.
// The back takes a new access only once it is through with the last one, and its
// write back waits while the receiver still holds the previous result.
// Reset: synchronous, active low; afterwards a clearing pass invalidates every set row
// before the first access is carried out.
// ----------------------------------------------------------------------------
// mesi_snooping_cache_array
// Per-processor set-associative caches kept coherent by MESI snooping.
// ----------------------------------------------------------------------------
`default_nettype none

module mesi_snooping_cache_array
    import msca_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_item_t    s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_item_t        m_data
);

    cfg_t       cfg_reg, cfg_next;
    reg_idx_t   reg_idx;
    logic       fq_valid, fq_ready, qb_valid, qb_ready;
    work_t      fq_data, qb_data;
    bk_status_t bk_status;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[3:2]);

    always_comb begin
        cfg_next = cfg_reg;
        prdata   = '0;
        unique case (reg_idx)
            REG_SET_INDEX:    prdata = 32'(cfg_reg.set_index_bits);
            REG_BLOCK_OFFSET: prdata = 32'(cfg_reg.block_offset_bits);
            REG_WAYS:         prdata = 32'(cfg_reg.ways_in_use);
            REG_PROCS:        prdata = 32'(cfg_reg.processors_in_use);
            default:          prdata = '0;
        endcase
        if (psel && penable && pwrite) begin
            unique case (reg_idx)
                REG_SET_INDEX:    cfg_next.set_index_bits    = pwdata[2:0];
                REG_BLOCK_OFFSET: cfg_next.block_offset_bits = pwdata[3:0];
                REG_WAYS:         cfg_next.ways_in_use       = pwdata[2:0];
                REG_PROCS:        cfg_next.processors_in_use = pwdata[2:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.set_index_bits    <= 3'd4;
            cfg_reg.block_offset_bits <= 4'd6;
            cfg_reg.ways_in_use       <= 3'd4;
            cfg_reg.processors_in_use <= 3'd4;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    msca_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .w_valid (fq_valid),
        .w_ready (fq_ready),
        .w_data  (fq_data)
    );

    msca_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    msca_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .w_valid (qb_valid),
        .w_ready (qb_ready),
        .w_data  (qb_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .status  (bk_status)
    );

`ifndef NO_ASSERTIONS
    a_no_result_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        bk_status.clearing |-> !m_valid)
        else $error("result beat during clearing pass");

    a_dirty_only_on_conflict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.dirty_eviction |-> m_data.outcome == OC_CONFLICT)
        else $error("dirty eviction without conflict miss");

    a_clear_after_reset: assert property (@(posedge aclk)
        aresetn && !$past(aresetn) |-> bk_status.clearing)
        else $error("no clearing pass after reset");
`endif

endmodule

`default_nettype wire

// ----- bench/mesi_snooping_cache_array_test.sv -----
// ----------------------------------------------------------------------------
// mesi_snooping_cache_array_test
// Drives random and directed accesses into the MESI cache array, predicts each
// result with a local model of the per-processor caches and compares them.
// ----------------------------------------------------------------------------
`default_nettype none

module mesi_snooping_cache_array_test;
    import msca_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;

    mesi_snooping_cache_array u_top (
        .aclk(aclk), .aresetn(aresetn), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready), .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    localparam int NLINES = PROCESSORS * MAX_SETS * WAYS;

    // Local copy of the cache state.
    logic                  c_valid [NLINES];
    coh_t                  c_coh   [NLINES];
    logic [ADDR_BITS-1:0]  c_addr  [NLINES];
    logic                  c_dirty [NLINES];
    logic [STAMP_BITS-1:0] c_stamp [NLINES];
    logic [STAMP_BITS-1:0] bus_count [PROCESSORS];
    logic [2:0] cfg_sib = 3'd4;
    logic [3:0] cfg_bob = 4'd6;
    logic [2:0] cfg_ways = 3'd4;
    logic [2:0] cfg_procs = 3'd4;

    out_item_t expected_q[$];
    int  mismatches = 0;
    bit  sink_hold = 1'b0;
    bit  no_idle = 1'b0;
    logic [ADDR_BITS-1:0] recent[$];

    function automatic int line_ix(int p, int s, int w);
        return (p * MAX_SETS + s) * WAYS + w;
    endfunction

    function automatic out_item_t predict_access(in_item_t it);
        out_item_t r;
        int nprocs, nways, sh, set, way, k;
        logic [ADDR_BITS-1:0] blk;
        logic [STAMP_BITS-1:0] lo;
        bit found, freed, wr;
        r = '0;
        wr = it.action;
        nprocs = (cfg_procs < 1) ? 1 : (cfg_procs > PROCESSORS ? PROCESSORS : cfg_procs);
        nways = (cfg_ways < 1) ? 1 : (cfg_ways > WAYS ? WAYS : cfg_ways);
        sh = cfg_bob;
        blk = it.access_address >> sh;
        set = int'(blk & ((48'd1 << cfg_sib) - 1)) % MAX_SETS;
        r.new_line_state = ST_I;
        r.outcome = OC_HIT;
        if (it.requester >= nprocs) return r;
        found = 1'b0;
        way = 0;
        for (int w = 0; w < nways; w++) begin
            k = line_ix(it.requester, set, w);
            if (!found && c_valid[k] && (c_addr[k] >> sh) == blk) begin
                found = 1'b1;
                way = w;
            end
        end
        if (found) begin
            k = line_ix(it.requester, set, way);
            if (c_coh[k] != ST_I && !(c_coh[k] == ST_S && wr)) begin
                if (wr && c_coh[k] == ST_E) begin
                    c_coh[k] = ST_M;
                    c_dirty[k] = 1'b1;
                end
                r.way_used = WAY_BITS'(way);
                r.new_line_state = c_coh[k];
                return r;
            end
        end
        r.bus_used = 1'b1;
        for (int q = 0; q < nprocs; q++) begin
            if (q == it.requester) continue;
            for (int w = 0; w < nways; w++) begin
                k = line_ix(q, set, w);
                if (c_valid[k] && (c_addr[k] >> sh) == blk && c_coh[k] != ST_I) begin
                    c_coh[k] = wr ? ST_I : ST_S;
                    c_dirty[k] = 1'b0;
                    r.copies_found = 1'b1;
                end
            end
        end
        if (found) begin
            k = line_ix(it.requester, set, way);
            if (c_coh[k] == ST_I) begin
                r.outcome = (c_addr[k] == it.access_address) ? OC_TRUE_SHARE : OC_FALSE_SHARE;
                c_coh[k] = wr ? ST_M : ST_S;
                c_dirty[k] = wr;
            end else begin
                r.outcome = OC_UPGRADE;
                c_coh[k] = ST_M;
                c_dirty[k] = 1'b1;
            end
        end else begin
            freed = 1'b0;
            for (int w = 0; w < nways; w++)
                if (!freed && !c_valid[line_ix(it.requester, set, w)]) begin
                    freed = 1'b1;
                    way = w;
                end
            if (freed) begin
                r.outcome = OC_COLD;
            end else begin
                lo = STAMP_MAX;
                way = 0;
                for (int w = 0; w < nways; w++)
                    if (c_stamp[line_ix(it.requester, set, w)] < lo) begin
                        lo = c_stamp[line_ix(it.requester, set, w)];
                        way = w;
                    end
                r.outcome = OC_CONFLICT;
                r.dirty_eviction = c_dirty[line_ix(it.requester, set, way)];
            end
            k = line_ix(it.requester, set, way);
            c_valid[k] = 1'b1;
            c_coh[k] = wr ? ST_M : (r.copies_found ? ST_S : ST_E);
            c_dirty[k] = wr;
        end
        c_addr[k] = it.access_address;
        c_stamp[k] = bus_count[it.requester];
        r.way_used = WAY_BITS'(way);
        r.new_line_state = c_coh[k];
        bus_count[it.requester] = bus_count[it.requester] + 1'b1;
        return r;
    endfunction

    // Leaves valid high after the beat; an idle gap in the next call or drain_results drops it.
    task automatic send_access(input bit wr, input logic [1:0] pid,
                               input logic [ADDR_BITS-1:0] addr);
        in_item_t it;
        it.action = wr;
        it.requester = pid;
        it.access_address = addr;
        while (!no_idle && $urandom_range(99) < 29) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_q.push_back(predict_access(it));
        if (recent.size() > 24) void'(recent.pop_front());
        recent.push_back(addr);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 4'(idx) << 2;
        pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_SET_INDEX:    cfg_sib = val[2:0];
            REG_BLOCK_OFFSET: cfg_bob = val[3:0];
            REG_WAYS:         cfg_ways = val[2:0];
            REG_PROCS:        cfg_procs = val[2:0];
        endcase
        @(negedge aclk);
    endtask

    task automatic set_config(input int sib, input int bob, input int nw, input int np);
        drain_results();
        write_reg(REG_SET_INDEX, sib);
        write_reg(REG_BLOCK_OFFSET, bob);
        write_reg(REG_WAYS, nw);
        write_reg(REG_PROCS, np);
    endtask

    // Mostly reuses recent blocks so sharing, upgrades and evictions occur.
    function automatic logic [ADDR_BITS-1:0] pick_address();
        logic [ADDR_BITS-1:0] a;
        int sel;
        sel = $urandom_range(9);
        if (sel < 6 && recent.size() != 0) begin
            a = recent[$urandom_range(recent.size() - 1)];
            if (sel < 2) a = a ^ ADDR_BITS'($urandom_range(63));
        end else if (sel < 9) begin
            a = ADDR_BITS'($urandom_range(4095)) << $urandom_range(8);
        end else begin
            a = ADDR_BITS'({$urandom, $urandom});
        end
        return a;
    endfunction

    task automatic random_accesses(input int count);
        for (int i = 0; i < count; i++)
            send_access(1'($urandom_range(1)), 2'($urandom_range(3)), pick_address());
    endtask

    task automatic test_directed();
        send_access(1'b0, 2'd0, 48'h0);
        send_access(1'b0, 2'd1, 48'h0);
        send_access(1'b1, 2'd1, 48'h0);
        send_access(1'b0, 2'd0, 48'h4);
        send_access(1'b0, 2'd0, 48'h0);
        send_access(1'b1, 2'd2, 48'h1000);
        send_access(1'b1, 2'd2, 48'h1000);
        send_access(1'b0, 2'd3, 48'hFFFF_FFFF_FFFF);
        send_access(1'b1, 2'd3, 48'hFFFF_FFFF_FFFF);
        for (int i = 0; i < 6; i++)
            send_access(i[0], 2'd0, 48'h10 + (48'h400 * i));
        send_access(1'b0, 2'd0, 48'hAAAA_5555_AAAA);
        send_access(1'b1, 2'd1, 48'h5555_AAAA_5555);
    endtask

    task automatic test_config_sweep();
        int sweep[6][4] = '{'{0, 0, 1, 1}, '{6, 12, 4, 4}, '{7, 15, 0, 0},
                            '{2, 3, 7, 7}, '{5, 1, 2, 3}, '{4, 6, 4, 4}};
        foreach (sweep[i]) begin
            set_config(sweep[i][0], sweep[i][1], sweep[i][2], sweep[i][3]);
            if (i == 2) send_access(1'b0, 2'd3, 48'h40);
            random_accesses(200);
        end
    endtask

    task automatic test_backpressure();
        sink_hold = 1'b1;
        no_idle = 1'b1;
        random_accesses(30);
        no_idle = 1'b0;
        random_accesses(250);
        drain_results();
        random_accesses(400);
        drain_results();
    endtask

    // Result checker.
    always @(posedge aclk) begin
        out_item_t e;
        if (m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %p", m_data);
            end else begin
                e = expected_q.pop_front();
                if (m_data !== e) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %p got %p", e, m_data);
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (sink_hold) m_ready <= 1'b0;
        else m_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 29);
    end

    // Long receiver hold-off so the block fills and stalls its input.
    initial begin
        wait (sink_hold);
        repeat (300) @(negedge aclk);
        sink_hold = 1'b0;
    end

    initial begin
        for (int i = 0; i < NLINES; i++) begin
            c_valid[i] = 1'b0;
            c_coh[i] = ST_I;
            c_addr[i] = '0;
            c_dirty[i] = 1'b0;
            c_stamp[i] = '0;
        end
        for (int p = 0; p < PROCESSORS; p++) bus_count[p] = '0;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_backpressure();
        test_config_sweep();
        drain_results();
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("mesi_snooping_cache_array test passed");
        end else begin
            $display("mesi_snooping_cache_array test failed");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("mesi_snooping_cache_array test failed");
        $finish;
    end

endmodule

`default_nettype wire
